// ===== rtl/core/bbd_pkg.sv =====
// Shared types and constants of the bilinear Bayer demosaic core.
package bbd_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // input word kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // frame size after reset, and smallest legal size
  localparam int RST_WIDTH  = 390;
  localparam int RST_HEIGHT = 300;
  localparam int MIN_DIM    = 3;

  // result buffer depth (also the credit limit on the input)
  localparam int OUT_DEPTH = 4;

  // GRBG site codes, {odd row, odd column}
  localparam logic [1:0] SITE_GR = 2'b00;
  localparam logic [1:0] SITE_R  = 2'b01;
  localparam logic [1:0] SITE_B  = 2'b10;
  localparam logic [1:0] SITE_GB = 2'b11;

  // 3x3 neighborhood, [row][column], column 2 newest
  typedef logic [2:0][2:0][PIX_W-1:0] bbd_win_t;

  // one line store entry: two rows back and one row back
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } bbd_lines_t;

  // position flags of the pixel being emitted
  typedef struct packed {
    logic top_m;
    logic bot_m;
    logic left_m;
    logic right_m;
    logic odd_row;
    logic odd_col;
    logic last;
  } bbd_pos_t;

  // one output word
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } bbd_pix_t;

endpackage

// ===== rtl/core/bbd_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bbd_interp.sv =====
// Bilinear interpolation of one GRBG pixel from its mirrored 3x3 window.
module bbd_interp (
  input  bbd_pkg::bbd_win_t win,
  input  bbd_pkg::bbd_pos_t pos,
  output bbd_pkg::bbd_pix_t pix
);
  import bbd_pkg::*;

  logic [1:0]       rt, rb, cl, cr;
  logic [PIX_W:0]   hsum, vsum;
  logic [PIX_W+1:0] xsum, dsum;
  logic [PIX_W-1:0] hor, ver, crs, dia, ctr;

  // mirror: missing neighbor row/column is replaced by the opposite one
  assign rt = pos.top_m   ? 2'd2 : 2'd0;
  assign rb = pos.bot_m   ? 2'd0 : 2'd2;
  assign cl = pos.left_m  ? 2'd2 : 2'd0;
  assign cr = pos.right_m ? 2'd0 : 2'd2;

  assign hsum = {1'b0, win[1][cl]} + {1'b0, win[1][cr]};
  assign vsum = {1'b0, win[rt][1]} + {1'b0, win[rb][1]};
  assign xsum = {1'b0, hsum} + {1'b0, vsum};
  assign dsum = {2'b0, win[rt][cl]} + {2'b0, win[rt][cr]}
              + {2'b0, win[rb][cl]} + {2'b0, win[rb][cr]};

  assign hor = hsum[PIX_W:1];
  assign ver = vsum[PIX_W:1];
  assign crs = xsum[PIX_W+1:2];
  assign dia = dsum[PIX_W+1:2];
  assign ctr = win[1][1];

  always_comb begin
    pix.frame_end = pos.last;
    case ({pos.odd_row, pos.odd_col})
      SITE_GR: begin
        pix.red = hor; pix.green = ctr; pix.blue = ver;
      end
      SITE_GB: begin
        pix.red = ver; pix.green = ctr; pix.blue = hor;
      end
      SITE_R: begin
        pix.red = ctr; pix.green = crs; pix.blue = dia;
      end
      SITE_B: begin
        pix.red = dia; pix.green = crs; pix.blue = ctr;
      end
      default: begin
        pix.red = hor; pix.green = ctr; pix.blue = ver;
      end
    endcase
  end

endmodule

// ===== rtl/core/bilinear_bayer_demosaic.sv =====
// Top level of the streaming bilinear GRBG Bayer demosaic.
// Throughput: one word per cycle, pixel or drain, sustained while out_ready holds high.
// Path: an emitting word passes the line store read, then the window shift, then
//   interpolation into the result buffer, before it shows on the output.
// An RGB pixel trails its raw sample by one row plus one pixel; W+1 drain words end a frame.
// Reset (rst_n low, synchronous) restores size 390x300, clears counters and buffer;
//   line store contents stay undefined until written, no clearing pass is needed.
module bilinear_bayer_demosaic #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data,
  // raw input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [bbd_pkg::PIX_W-1:0]      in_raw_pixel,
  // RGB output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bbd_pkg::PIX_W-1:0]      out_red,
  output logic [bbd_pkg::PIX_W-1:0]      out_green,
  output logic [bbd_pkg::PIX_W-1:0]      out_blue,
  output logic                           out_frame_end
);
  import bbd_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);   // column counter / line store address
  localparam int RW    = $clog2(MAX_HEIGHT);  // row counter, holds up to the height
  localparam int OPW   = $clog2(OUT_DEPTH);
  localparam int CRW   = $clog2(OUT_DEPTH + 1);
  localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int RST_H = (RST_HEIGHT > MAX_HEIGHT - 1) ? MAX_HEIGHT - 1 : RST_HEIGHT;

  // ---------------------------------------------------------------------------
  // Frame size. Stored as last column / last row, already clamped to the
  // legal range, so the stream logic compares against them with no clamping.
  // ---------------------------------------------------------------------------
  logic                    cfg_fire, cfg_hit;
  logic [WIDTH_REG_W-1:0]  cfg_w_val;
  logic [HEIGHT_REG_W-1:0] cfg_h_val;
  logic [CW-1:0]           w_last_r, w_last_cfg;
  logic [RW-1:0]           h_last_r, h_last_cfg;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  // any write to a real register restarts the frame
  assign cfg_hit   = cfg_fire && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign cfg_w_val = cfg_data[WIDTH_REG_W-1:0];
  assign cfg_h_val = cfg_data[HEIGHT_REG_W-1:0];

  always_comb begin
    if (cfg_w_val < WIDTH_REG_W'(MIN_DIM)) begin
      w_last_cfg = CW'(MIN_DIM - 1);
    end else if (32'(cfg_w_val) > MAX_WIDTH) begin
      w_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_cfg = CW'(cfg_w_val - WIDTH_REG_W'(1));
    end
    if (cfg_h_val < HEIGHT_REG_W'(MIN_DIM)) begin
      h_last_cfg = RW'(MIN_DIM - 1);
    end else if (32'(cfg_h_val) > MAX_HEIGHT - 1) begin
      h_last_cfg = RW'(MAX_HEIGHT - 2);
    end else begin
      h_last_cfg = RW'(cfg_h_val - HEIGHT_REG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(RST_W - 1);
      h_last_r <= RW'(RST_H - 1);
    end else if (cfg_fire) begin
      if (cfg_index == REG_WIDTH) begin
        w_last_r <= w_last_cfg;
      end
      if (cfg_index == REG_HEIGHT) begin
        h_last_r <= h_last_cfg;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: decide what the word does, advance the raster counters and
  // issue the line store read.
  //   pixel word: taken while the frame is still filling, read at its column
  //   drain word: taken once all pixels are in, read one column ahead of output
  // A word of the wrong kind for the frame phase is swallowed with no effect.
  // ---------------------------------------------------------------------------
  logic          in_fire, out_fire;
  logic          frame_done, is_drain;
  logic          pix_go, drn_go, pix_emits, emit_go;
  logic          in_last_col, oc_wrap, or_last;
  logic [CW-1:0] ic_r, ic_nxt, oc_r, oc_nxt;
  logic [RW-1:0] ir_r, ir_nxt, or_r, or_nxt;
  logic [CW-1:0] drain_addr, rd_addr;
  bbd_pos_t      pos_new;
  logic [CRW-1:0] credit_r;

  // credit covers every result in flight plus those buffered, so the buffer
  // never overflows and the input never waits on out_ready combinationally
  assign in_ready = credit_r < CRW'(OUT_DEPTH);
  assign in_fire  = in_valid && in_ready;

  assign frame_done = ir_r > h_last_r;
  assign is_drain   = in_mode == MODE_DRAIN;
  assign pix_go     = in_fire && !is_drain && !frame_done;
  assign drn_go     = in_fire && is_drain && frame_done;
  // first output needs row 1 column 1 in hand
  assign pix_emits  = (ir_r >= RW'(2)) || (ir_r == RW'(1) && ic_r != '0);
  assign emit_go    = (pix_go && pix_emits) || drn_go;

  assign in_last_col = ic_r == w_last_r;
  assign oc_wrap     = oc_r == w_last_r;
  assign or_last     = or_r == h_last_r;
  assign drain_addr  = oc_wrap ? '0 : oc_r + CW'(1);
  assign rd_addr     = is_drain ? drain_addr : ic_r;

  // border flags pick mirrored neighbors later on
  assign pos_new.top_m   = or_r == '0;
  assign pos_new.bot_m   = or_last;
  assign pos_new.left_m  = oc_r == '0;
  assign pos_new.right_m = oc_wrap;
  assign pos_new.odd_row = or_r[0];
  assign pos_new.odd_col = oc_r[0];
  assign pos_new.last    = or_last && oc_wrap;

  always_comb begin
    ic_nxt = ic_r;
    ir_nxt = ir_r;
    oc_nxt = oc_r;
    or_nxt = or_r;
    if (cfg_hit) begin
      ic_nxt = '0;
      ir_nxt = '0;
      oc_nxt = '0;
      or_nxt = '0;
    end else begin
      if (pix_go) begin
        if (in_last_col) begin
          ic_nxt = '0;
          ir_nxt = ir_r + RW'(1);
        end else begin
          ic_nxt = ic_r + CW'(1);
        end
      end
      if (emit_go) begin
        if (pos_new.last) begin
          // frame fully delivered: everything starts over
          ic_nxt = '0;
          ir_nxt = '0;
          oc_nxt = '0;
          or_nxt = '0;
        end else if (oc_wrap) begin
          oc_nxt = '0;
          or_nxt = or_r + RW'(1);
        end else begin
          oc_nxt = oc_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= '0;
      ir_r <= '0;
      oc_r <= '0;
      or_r <= '0;
    end else begin
      ic_r <= ic_nxt;
      ir_r <= ir_nxt;
      oc_r <= oc_nxt;
      or_r <= or_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store data arrives. Pixel words write back {middle, pixel}
  // to the same entry (upper takes the old middle), and the new column shifts
  // into the window. Consecutive accesses to one column are at least a row
  // apart (width >= 3), and drains never write, so read and write never meet
  // on one entry and no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic             s1_valid_r, s1_wr_r, s1_emit_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_addr_r;
  bbd_pos_t         s1_pos_r;
  logic             ram_rd_en, ram_wr_en;
  bbd_lines_t       ram_rd_data, ram_wr_data;

  assign ram_rd_en = pix_go || drn_go;
  assign ram_wr_en = s1_valid_r && s1_wr_r;
  assign ram_wr_data.upper  = ram_rd_data.middle;
  assign ram_wr_data.middle = s1_pix_r;

  bbd_ram #(
    .WIDTH ($bits(bbd_lines_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= pix_go || drn_go;
    end
    s1_wr_r   <= pix_go;
    s1_emit_r <= emit_go;
    s1_addr_r <= rd_addr;
    s1_pos_r  <= pos_new;
    // drains push a zero bottom row; mirroring keeps it out of every result
    s1_pix_r  <= (in_mode == MODE_PIXEL) ? in_raw_pixel : '0;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window holds the neighborhood of the output pixel; interpolate
  // and push into the result buffer.
  // ---------------------------------------------------------------------------
  bbd_win_t win_r;
  logic     s2_push_r;
  bbd_pos_t s2_pos_r;
  bbd_pix_t interp_pix;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= ram_rd_data.upper;
      win_r[1][2] <= ram_rd_data.middle;
      win_r[2][2] <= s1_pix_r;
      s2_pos_r    <= s1_pos_r;
    end
    if (!rst_n) begin
      s2_push_r <= 1'b0;
    end else begin
      s2_push_r <= s1_valid_r && s1_emit_r;
    end
  end

  bbd_interp u_interp (
    .win (win_r),
    .pos (s2_pos_r),
    .pix (interp_pix)
  );

  // ---------------------------------------------------------------------------
  // Result buffer: small register FIFO that decouples the pipe from out_ready.
  // ---------------------------------------------------------------------------
  bbd_pix_t       fifo_mem_r [OUT_DEPTH];
  logic [OPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CRW-1:0] fill_r;

  assign out_valid     = fill_r != '0;
  assign out_fire      = out_valid && out_ready;
  assign out_red       = fifo_mem_r[rd_ptr_r].red;
  assign out_green     = fifo_mem_r[rd_ptr_r].green;
  assign out_blue      = fifo_mem_r[rd_ptr_r].blue;
  assign out_frame_end = fifo_mem_r[rd_ptr_r].frame_end;

  always_ff @(posedge clk) begin
    if (s2_push_r) begin
      fifo_mem_r[wr_ptr_r] <= interp_pix;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      if (s2_push_r) begin
        wr_ptr_r <= wr_ptr_r + OPW'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + OPW'(1);
      end
      fill_r   <= fill_r + CRW'(s2_push_r) - CRW'(out_fire);
      credit_r <= credit_r + CRW'(emit_go) - CRW'(out_fire);
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_rd_en && ram_wr_en && rd_addr == s1_addr_r))
    else $error("line store read and write hit the same entry");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(OUT_DEPTH) && fill_r <= credit_r)
    else $error("result credit out of bounds");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> ##2 s2_push_r)
    else $error("emitting word did not reach the result buffer");

  a_restart_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && pos_new.last && !cfg_hit) |=> (ir_r == '0 && or_r == '0 && oc_r == '0))
    else $error("counters not cleared after last pixel");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the GRBG bilinear demosaic: directed table, random frames, stalls.
`timescale 1ns / 100ps

module testbench;
  import bbd_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int ROW_LIMIT  = 4096;
  // idle margin after the last owed word is back, so the pipe can empty
  localparam int SETTLE_CYC = 8;
  // long receiver hold-off, well past the four-entry result buffer
  localparam int LONG_HOLD  = 300;
  // random part stops once this many pixel and flush words have been taken
  localparam int RAND_WORDS = 260;
  // unmapped register index; a write there must leave everything alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {FR_CLEAN, FR_NOISY, FR_BROKEN} frame_style_e;

  // one row of the directed table: the word to send and the result it must give
  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pix;
    logic             hit;
    bbd_pix_t         want;
  } drill_row_t;

  localparam bbd_pix_t NO_PIX    = '0;
  localparam bbd_pix_t WHITE     = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, frame_end: 1'b0};
  localparam bbd_pix_t WHITE_END = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, frame_end: 1'b1};

  // 3x3 frame of full-scale samples: every mean of 255s is 255, whatever the
  // mirroring picks, so the expected words are plain white.
  localparam int DRILL_ROWS = 16;
  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    '{MODE_DRAIN, 8'h00, 1'b0, NO_PIX},     // flush before the frame is in: ignored
    '{MODE_PIXEL, 8'hFF, 1'b0, NO_PIX},     // row 0
    '{MODE_PIXEL, 8'hFF, 1'b0, NO_PIX},
    '{MODE_PIXEL, 8'hFF, 1'b0, NO_PIX},
    '{MODE_PIXEL, 8'hFF, 1'b0, NO_PIX},     // row 1, col 0: still no output
    '{MODE_PIXEL, 8'hFF, 1'b1, WHITE},      // out (0,0), top and left mirrored
    '{MODE_PIXEL, 8'hFF, 1'b1, WHITE},      // out (0,1)
    '{MODE_PIXEL, 8'hFF, 1'b1, WHITE},      // out (0,2), right mirrored
    '{MODE_PIXEL, 8'hFF, 1'b1, WHITE},      // out (1,0)
    '{MODE_PIXEL, 8'hFF, 1'b1, WHITE},      // out (1,1)
    '{MODE_PIXEL, 8'h00, 1'b0, NO_PIX},     // frame already complete: dropped
    '{MODE_DRAIN, 8'h5A, 1'b1, WHITE},      // out (1,2)
    '{MODE_DRAIN, 8'hA5, 1'b1, WHITE},      // out (2,0), bottom mirrored
    '{MODE_DRAIN, 8'h00, 1'b1, WHITE},      // out (2,1)
    '{MODE_DRAIN, 8'hFF, 1'b1, WHITE_END},  // out (2,2), last of frame
    '{MODE_DRAIN, 8'h00, 1'b0, NO_PIX}      // counters cleared: flush ignored
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [PIX_W-1:0]      in_raw_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      out_red;
  logic [PIX_W-1:0]      out_green;
  logic [PIX_W-1:0]      out_blue;
  logic                  out_frame_end;

  bilinear_bayer_demosaic #(
    .MAX_WIDTH  (LINE_DEPTH),
    .MAX_HEIGHT (ROW_LIMIT)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_raw_pixel  (in_raw_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Demosaic predictor: its own copy of the size registers, line stores,
  // 3x3 neighborhood and the input/output raster counters.
  // ---------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [PIX_W-1:0]        line_up  [LINE_DEPTH];   // two rows back
  logic [PIX_W-1:0]        line_mid [LINE_DEPTH];   // one row back
  logic [PIX_W-1:0]        nbhd [3][3];             // [row][col], col 2 newest
  int unsigned             col_in, row_in, col_out, row_out;

  bbd_pix_t rgb_due [$];     // RGB words still owed by the block, oldest first
  int       bad_words;
  bit       hold_armed;      // asks the receiver for one long hold-off
  bit       tail_quiet;      // no idling on either side from here on

  // sizes saturate into the legal range
  function automatic int unsigned frame_w();
    int unsigned w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned frame_h();
    int unsigned h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > ROW_LIMIT - 1) h = ROW_LIMIT - 1;
    return h;
  endfunction

  function automatic void restart_counters();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  function automatic void shift_in(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] mid,
                                   input logic [PIX_W-1:0] bot);
    for (int k = 0; k < 3; k++) begin
      nbhd[k][0] = nbhd[k][1];
      nbhd[k][1] = nbhd[k][2];
    end
    nbhd[0][2] = top;
    nbhd[1][2] = mid;
    nbhd[2][2] = bot;
  endfunction

  // interpolate the pixel at (row_out, col_out), then step the output raster
  function automatic bbd_pix_t emit_rgb(input int unsigned w, input int unsigned h);
    int unsigned ro, co, hor, ver, crs, dia, ctr;
    int          t, b, l, r;
    bbd_pix_t    px;
    ro = row_out;
    co = col_out;
    // at the borders the mirrored neighbor sits on the other side of the center
    t = (ro == 0) ? 2 : 0;
    b = (ro == h - 1) ? 0 : 2;
    l = (co == 0) ? 2 : 0;
    r = (co == w - 1) ? 0 : 2;
    hor = (32'(nbhd[1][l]) + 32'(nbhd[1][r])) >> 1;
    ver = (32'(nbhd[t][1]) + 32'(nbhd[b][1])) >> 1;
    crs = (32'(nbhd[1][l]) + 32'(nbhd[1][r]) + 32'(nbhd[t][1]) + 32'(nbhd[b][1])) >> 2;
    dia = (32'(nbhd[t][l]) + 32'(nbhd[t][r]) + 32'(nbhd[b][l]) + 32'(nbhd[b][r])) >> 2;
    ctr = nbhd[1][1];
    case ({ro[0], co[0]})
      SITE_GR: begin
        px.red = hor[7:0]; px.green = ctr[7:0]; px.blue = ver[7:0];
      end
      SITE_GB: begin
        px.red = ver[7:0]; px.green = ctr[7:0]; px.blue = hor[7:0];
      end
      SITE_R: begin
        px.red = ctr[7:0]; px.green = crs[7:0]; px.blue = dia[7:0];
      end
      default: begin
        px.red = dia[7:0]; px.green = crs[7:0]; px.blue = ctr[7:0];
      end
    endcase
    px.frame_end = (ro == h - 1) && (co == w - 1);
    if (px.frame_end) begin
      restart_counters();
    end else if (co + 1 >= w) begin
      col_out = 0;
      row_out = ro + 1;
    end else begin
      col_out = co + 1;
    end
    return px;
  endfunction

  // one accepted input word; hit tells whether it yields an RGB word
  function automatic void demosaic_word(input logic mode, input logic [PIX_W-1:0] pix,
                                        output bit hit, output bbd_pix_t px);
    int unsigned w, h, c, r;
    bit          done;
    w    = frame_w();
    h    = frame_h();
    done = row_in >= h;
    hit  = 1'b0;
    px   = '0;
    if (mode == MODE_PIXEL) begin
      // once the whole frame is in, pixels are dropped until the flush ends
      if (!done) begin
        c = col_in;
        r = row_in;
        if (c >= w) c = 0;
        shift_in(line_up[c], line_mid[c], pix);
        line_up[c]  = line_mid[c];
        line_mid[c] = pix;
        if (c + 1 >= w) begin
          col_in = 0;
          row_in = r + 1;
        end else begin
          col_in = c + 1;
        end
        // output trails input by one row plus one pixel
        if (r >= 2 || (r == 1 && c >= 1)) begin
          hit = 1'b1;
          px  = emit_rgb(w, h);
        end
      end
    end else if (done) begin
      // flush word: bottom row is padding, mirroring keeps it out of the math
      c = col_out + 1;
      if (c >= w) c = 0;
      shift_in(line_up[c], line_mid[c], '0);
      hit = 1'b1;
      px  = emit_rgb(w, h);
    end
  endfunction

  function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_WIDTH) begin
      width_reg = data[WIDTH_REG_W-1:0];
      restart_counters();
    end else if (idx == REG_HEIGHT) begin
      height_reg = data[HEIGHT_REG_W-1:0];
      restart_counters();
    end
  endfunction

  function automatic void note_fail(input string msg);
    bad_words++;
    if (bad_words <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side. Everything changes on the falling edge; handshakes are
  // sampled on the rising edge. Each task returns on a falling edge.
  // ---------------------------------------------------------------------------

  // present one input word, wait for it to be taken, book its expected result;
  // a typed expectation overrides the predictor's, whose state still advances
  task automatic take_word(input logic mode, input logic [PIX_W-1:0] pix,
                           input bit typed = 1'b0, input bit typed_hit = 1'b0,
                           input bbd_pix_t typed_px = '0);
    bit       hit;
    bbd_pix_t px;
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_raw_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    demosaic_word(mode, pix, hit, px);
    if (typed) begin
      hit = typed_hit;
      px  = typed_px;
    end
    if (hit) rgb_due.push_back(px);
    @(negedge clk);
  endtask

  task automatic pause_tx(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // sender idles until every owed word is back, then lets the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (rgb_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic feed_word(input logic mode, input logic [PIX_W-1:0] pix, input bit calm);
    if (!calm && !tail_quiet && $urandom_range(0, 3) == 0) pause_tx($urandom_range(1, 16));
    take_word(mode, pix);
  endtask

  // samples lean on the rails now and then
  function automatic logic [PIX_W-1:0] raw_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // small random frame size; sometimes below the minimum to hit saturation
  task automatic new_size(input bit both);
    logic [CFG_DATA_W-1:0] w, h;
    w = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                    : CFG_DATA_W'($urandom_range(3, 10));
    h = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                    : CFG_DATA_W'($urandom_range(3, 6));
    if (both) begin
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
    end else if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_WIDTH, w);
    end else begin
      write_reg(REG_HEIGHT, h);
    end
  endtask

  // one frame at the current size. Noisy frames sprinkle early flushes, surplus
  // pixels and surplus flushes; broken frames stop part way through.
  task automatic stream_frame(input frame_style_e style, input bit calm, inout int taken);
    int unsigned w, h, n_px;
    w    = frame_w();
    h    = frame_h();
    n_px = (style == FR_BROKEN) ? $urandom_range(1, w * h - 1) : w * h;
    for (int unsigned i = 0; i < n_px; i++) begin
      if (style == FR_NOISY && $urandom_range(0, 9) == 0)
        feed_word(MODE_DRAIN, raw_sample(), calm);
      feed_word(MODE_PIXEL, raw_sample(), calm);
    end
    taken += n_px;
    if (style != FR_BROKEN) begin
      if (style == FR_NOISY) repeat ($urandom_range(0, 3)) feed_word(MODE_PIXEL, raw_sample(), calm);
      repeat (w + 1) feed_word(MODE_DRAIN, raw_sample(), calm);
      taken += w + 1;
      if (style == FR_NOISY) repeat ($urandom_range(0, 2)) feed_word(MODE_DRAIN, raw_sample(), calm);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side: random stall bursts, calm stretches, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int calm_left;
    calm_left = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        // sender keeps offering: the result buffer fills and in_ready drops
        hold_armed = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!tail_quiet && calm_left == 0 && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else if (calm_left == 0 && $urandom_range(0, 39) == 0) begin
        calm_left = $urandom_range(30, 120);
      end
      out_ready <= 1'b1;
      if (calm_left > 0) calm_left--;
    end
  end

  // compare every accepted RGB word with the oldest owed one
  always @(posedge clk) begin
    bbd_pix_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_red, out_green, out_blue, out_frame_end};
      if (rgb_due.size() == 0) begin
        note_fail($sformatf("unexpected word: r=%0d g=%0d b=%0d end=%0b",
                            got.red, got.green, got.blue, got.frame_end));
      end else begin
        want = rgb_due.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.frame_end !== want.frame_end) begin
          note_fail($sformatf({"word mismatch: expected r=%0d g=%0d b=%0d end=%0b, ",
                               "got r=%0d g=%0d b=%0d end=%0b"},
                              want.red, want.green, want.blue, want.frame_end,
                              got.red, got.green, got.blue, got.frame_end));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int           taken;
    int           u;
    bit           restart_due;
    frame_style_e style;

    // predictor state after reset; line stores start at zero here, the
    // entries the hardware leaves undefined are never selected
    width_reg  = RST_WIDTH;
    height_reg = RST_HEIGHT;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    nbhd = '{default: '0};
    restart_counters();
    bad_words  = 0;
    hold_armed = 1'b0;
    tail_quiet = 1'b0;

    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_mode      = MODE_PIXEL;
    in_raw_pixel = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: 3x3 frame, height written below the minimum (saturates to 3),
    // plus a write to the unmapped index that must change nothing
    write_reg(REG_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_HEIGHT, '0);
    write_reg(REG_SPARE, '1);
    for (int i = 0; i < DRILL_ROWS; i++)
      take_word(DRILL[i].mode, DRILL[i].pix, 1'b1, DRILL[i].hit, DRILL[i].want);
    settle();

    // mid-size frame with no sender idling, so the long hold-off backs the
    // block up to its input
    write_reg(REG_WIDTH, CFG_DATA_W'(12));
    write_reg(REG_HEIGHT, CFG_DATA_W'(4));
    hold_armed = 1'b1;
    taken = 0;
    stream_frame(FR_CLEAN, 1'b1, taken);
    settle();

    // short noisy frame with the width below the minimum
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, CFG_DATA_W'(5));
    stream_frame(FR_NOISY, 1'b0, taken);

    // random small frames; a broken frame is always followed by a rewrite,
    // which restarts the raster
    taken       = 0;
    restart_due = 1'b1;
    while (taken < RAND_WORDS) begin
      if (restart_due || $urandom_range(0, 2) == 0) begin
        settle();
        new_size(restart_due && taken == 0);
        restart_due = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        settle();
      end
      u = $urandom_range(0, 9);
      style = (u < 6) ? FR_CLEAN : (u < 9) ? FR_NOISY : FR_BROKEN;
      stream_frame(style, $urandom_range(0, 3) == 0, taken);
      if (style == FR_BROKEN) restart_due = 1'b1;
    end

    // closing frame at full rate, no idling anywhere
    settle();
    new_size(1'b1);
    tail_quiet = 1'b1;
    stream_frame(FR_CLEAN, 1'b1, taken);
    in_valid <= 1'b0;

    while (rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (bad_words == 0 && rgb_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run (60 ms)
  initial begin
    #60000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
